### hw/rtl/line_segment_extent_core_macros.svh
// assertion helpers for the line segment extent core
// used by the top level only, no other dependencies
`ifndef LINE_SEGMENT_EXTENT_CORE_MACROS_SVH
`define LINE_SEGMENT_EXTENT_CORE_MACROS_SVH

// consequent must hold at the same edge as the antecedent
`define LSE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line_segment_extent_core: check failed");

// consequent must hold at the edge after the antecedent
`define LSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line_segment_extent_core: check failed");

`endif

### hw/rtl/lse_pkg.sv
// shared types, widths and constants of the line segment extent core
// no dependencies
`timescale 1ns / 1ps

package lse_pkg;

   // field and datapath widths
   localparam int AXES        = 3;
   localparam int COORD_W     = 32;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int PROD_W      = DIFF_W + COORD_W;
   localparam int Q30_SHIFT   = 30;
   localparam int RND_W       = PROD_W - Q30_SHIFT;
   localparam int PROJ_W      = 36;
   localparam int LEN_W       = PROJ_W;
   localparam int SCALED_W    = LEN_W + 2;
   localparam int XL_W        = 18;
   localparam int XH_W        = LEN_W - XL_W;
   localparam int RECIP_W     = 37;
   localparam int MPROD_W     = XH_W + RECIP_W;
   localparam int QPROD_W     = MPROD_W + XL_W;
   localparam int RECIP_SHIFT = 39;
   localparam int QUOT_W      = QPROD_W - RECIP_SHIFT;
   localparam int T_W         = PROJ_W + 1;
   localparam int TL_W        = 16;
   localparam int TH_W        = T_W - TL_W;
   localparam int EHI_W       = TH_W + COORD_W;
   localparam int ELO_W       = TL_W + 1 + COORD_W;
   localparam int EPROD_W     = T_W + COORD_W;
   localparam int ERND_W      = EPROD_W - Q30_SHIFT;
   localparam int EXT_W       = ERND_W + 1;
   localparam int CSR_INDEX_W = 3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_POINT_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_POINT_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_POINT_Z = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_X        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_Y        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_Z        = 3'd5;

   // arithmetic constants
   localparam logic signed [Q30_SHIFT:0] Q30_HALF = 31'sd536870912;
   localparam logic signed [PROJ_W-1:0] PROJ_MAX = {1'b0, {(PROJ_W-1){1'b1}}};
   localparam logic signed [PROJ_W-1:0] PROJ_MIN = {1'b1, {(PROJ_W-1){1'b0}}};
   // margin = (3 * len + 10) / 20, done as ((3 * len + 10) >> 2) / 5
   localparam logic [3:0] MARGIN_BIAS = 4'd10;
   // ceil(2^39 / 5), exact quotient for every 36-bit dividend
   localparam logic [RECIP_W-1:0] RECIP_FIVE = 37'd109951162778;
   // 0.08 m in Q16.16
   localparam logic [QUOT_W-1:0] MARGIN_MIN = 34'd5243;
   // 0.5 m in Q16.16
   localparam logic signed [T_W-1:0] HALF_METRE = 37'sd32768;
   localparam logic signed [COORD_W-1:0] DIR_ONE = 32'sd1073741824;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [PROJ_W-1:0] proj_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      logic      point_valid;
      logic      set_last;
   } req_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type start_z;
      coord_type finish_x;
      coord_type finish_y;
      coord_type finish_z;
      logic      used_fallback;
   } rsp_type;

   typedef struct packed {
      coord_type line_point_x;
      coord_type line_point_y;
      coord_type line_point_z;
      coord_type dir_x;
      coord_type dir_y;
      coord_type dir_z;
   } cfg_type;

   // projection range of one set
   typedef struct packed {
      proj_type min_proj;
      proj_type max_proj;
      logic     seen;
   } extent_type;

   localparam cfg_type CFG_RESET = '{
      line_point_x: '0, line_point_y: '0, line_point_z: '0,
      dir_x: DIR_ONE, dir_y: '0, dir_z: '0
   };

   localparam extent_type EXTENT_CLEAR = '{
      min_proj: PROJ_MAX, max_proj: PROJ_MIN, seen: 1'b0
   };

endpackage

### hw/rtl/line_segment_extent_core.sv
// top level of the line segment extent core: config registers and the two datapath parts
// depends on lse_pkg, lse_range, lse_endpoints and line_segment_extent_core_macros.svh
`timescale 1ns / 1ps
`include "line_segment_extent_core_macros.svh"

// Usage
//   req_*: one beat per point, with point_valid and set_last. A beat with set_last
//   closes the set; exactly that beat produces one rsp_* beat holding the start and
//   finish of the widened segment, or line point -/+ 0.5 m along the direction with
//   used_fallback set when the set held no valid point.
//   csr_*: write line point (Q16.16) and unit direction (Q2.30) while no set is open
//   and no result is pending; indexes past dir_z are ignored.
// Throughput: one beat per cycle while req_stall is low. Path: the closing beat is
//   accepted into the input register, then passes the product register, range capture
//   register and five finishing stages: length, reciprocal divide by five, margin,
//   endpoint products, round and saturate into the result register.
// Reset: synchronous; empties the pipe, clears the running range and loads the
//   default line (origin, direction +x).
// Stall: a stalled result holds in its register. Points that do not close a set keep
//   flowing; req_stall rises only once the finishing stages are full of pending results.

module line_segment_extent_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lse_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lse_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [lse_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lse_pkg::COORD_W-1:0]         csr_wdata
);

   lse_pkg::cfg_type    cfg_ff;
   lse_pkg::cfg_type    cfg_in;
   logic                snap_valid;
   logic                snap_ready;
   lse_pkg::extent_type snap_data;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            lse_pkg::CSR_LINE_POINT_X: cfg_in.line_point_x = csr_wdata;
            lse_pkg::CSR_LINE_POINT_Y: cfg_in.line_point_y = csr_wdata;
            lse_pkg::CSR_LINE_POINT_Z: cfg_in.line_point_z = csr_wdata;
            lse_pkg::CSR_DIR_X:        cfg_in.dir_x        = csr_wdata;
            lse_pkg::CSR_DIR_Y:        cfg_in.dir_y        = csr_wdata;
            lse_pkg::CSR_DIR_Z:        cfg_in.dir_z        = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= lse_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // projection and running range
   lse_range u_range (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap_data  (snap_data)
   );

   // margin and segment endpoints
   lse_endpoints u_endpoints (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap_data  (snap_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // input only backs up behind a stalled result
   `LSE_ASSERT_SAME(a_stall_source, clock, reset, req_stall, rsp_valid && rsp_stall)
   // no result straight out of reset
   `LSE_ASSERT_SAME(a_empty_after_reset, clock, reset, $past(reset), !rsp_valid)
   // a set with a point has an ordered range
   `LSE_ASSERT_SAME(a_range_ordered, clock, reset, snap_valid && snap_data.seen, snap_data.max_proj >= snap_data.min_proj)

endmodule

### hw/rtl/lse_range.sv
// input register, projection onto the line and running min/max of one set
// depends on lse_pkg
`timescale 1ns / 1ps

module lse_range (
   input  logic                clock,
   input  logic                reset,
   input  lse_pkg::cfg_type    cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  lse_pkg::req_type    req_data,
   output logic                snap_valid,
   input  logic                snap_ready,
   output lse_pkg::extent_type snap_data
);

   logic                             a_vld_ff;
   lse_pkg::req_type                 a_data_ff;
   logic                             a_rdy;
   logic                             b_vld_ff;
   logic                             b_pv_ff;
   logic                             b_last_ff;
   logic signed [lse_pkg::PROD_W-1:0] b_prod_ff [lse_pkg::AXES];
   logic signed [lse_pkg::PROD_W-1:0] b_prod_in [lse_pkg::AXES];
   logic                             b_rdy;
   logic                             b_fire;
   lse_pkg::coord_type               pt [lse_pkg::AXES];
   lse_pkg::coord_type               lp [lse_pkg::AXES];
   lse_pkg::coord_type               dir [lse_pkg::AXES];
   logic signed [lse_pkg::DIFF_W-1:0] diff [lse_pkg::AXES];
   logic signed [lse_pkg::PROD_W-1:0] biased [lse_pkg::AXES];
   logic signed [lse_pkg::RND_W-1:0]  rnd [lse_pkg::AXES];
   lse_pkg::proj_type                proj;
   lse_pkg::extent_type              ext_ff;
   lse_pkg::extent_type              ext_in;
   lse_pkg::extent_type              ext_upd;

   // backpressure: only a last beat waits on the finishing pipe
   assign b_rdy     = !b_vld_ff || !b_last_ff || snap_ready;
   assign b_fire    = b_vld_ff && b_rdy;
   assign a_rdy     = !a_vld_ff || b_rdy;
   assign req_stall = !a_rdy;

   // stage a: input register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (a_rdy) begin
         a_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_rdy && req_valid) begin
         a_data_ff <= req_data;
      end
   end

   // per axis operands
   assign pt[0]  = a_data_ff.point_x;
   assign pt[1]  = a_data_ff.point_y;
   assign pt[2]  = a_data_ff.point_z;
   assign lp[0]  = cfg.line_point_x;
   assign lp[1]  = cfg.line_point_y;
   assign lp[2]  = cfg.line_point_z;
   assign dir[0] = cfg.dir_x;
   assign dir[1] = cfg.dir_y;
   assign dir[2] = cfg.dir_z;

   // offset from the line point times direction, full precision
   always_comb begin
      for (int i = 0; i < lse_pkg::AXES; i++) begin
         diff[i] = lse_pkg::DIFF_W'(pt[i]) - lse_pkg::DIFF_W'(lp[i]);
         b_prod_in[i] = diff[i] * dir[i];
      end
   end

   // stage b: product register
   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (b_rdy) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_rdy && a_vld_ff) begin
         b_pv_ff   <= a_data_ff.point_valid;
         b_last_ff <= a_data_ff.set_last;
         for (int i = 0; i < lse_pkg::AXES; i++) begin
            b_prod_ff[i] <= b_prod_in[i];
         end
      end
   end

   // round each product half up to Q16.16, then sum the axes
   always_comb begin
      for (int i = 0; i < lse_pkg::AXES; i++) begin
         biased[i] = b_prod_ff[i] + lse_pkg::Q30_HALF;
         rnd[i]    = biased[i][lse_pkg::PROD_W-1:lse_pkg::Q30_SHIFT];
      end
   end

   assign proj = lse_pkg::PROJ_W'(rnd[0]) + lse_pkg::PROJ_W'(rnd[1])
               + lse_pkg::PROJ_W'(rnd[2]);

   // fold the point into the range
   always_comb begin
      ext_upd = ext_ff;
      if (b_pv_ff) begin
         if (proj < ext_ff.min_proj) begin
            ext_upd.min_proj = proj;
         end
         if (proj > ext_ff.max_proj) begin
            ext_upd.max_proj = proj;
         end
         ext_upd.seen = 1'b1;
      end
   end

   // a last beat hands the range on and starts a fresh set
   always_comb begin
      ext_in = ext_ff;
      if (b_fire) begin
         ext_in = b_last_ff ? lse_pkg::EXTENT_CLEAR : ext_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff <= lse_pkg::EXTENT_CLEAR;
      end else begin
         ext_ff <= ext_in;
      end
   end

   assign snap_valid = b_vld_ff && b_last_ff;
   assign snap_data  = ext_upd;

endmodule

### hw/rtl/lse_endpoints.sv
// widening of the range and the two segment endpoints, with the result register
// depends on lse_pkg
`timescale 1ns / 1ps

module lse_endpoints (
   input  logic                clock,
   input  logic                reset,
   input  lse_pkg::cfg_type    cfg,
   input  logic                snap_valid,
   output logic                snap_ready,
   input  lse_pkg::extent_type snap_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lse_pkg::rsp_type    rsp_data
);

   logic c_vld_ff, d_vld_ff, e_vld_ff, f_vld_ff, g_vld_ff, rsp_vld_ff;
   logic c_rdy, d_rdy, e_rdy, f_rdy, g_rdy, rsp_free;

   lse_pkg::extent_type                c_ext_ff;
   logic signed [lse_pkg::PROJ_W:0]    span;
   logic [lse_pkg::LEN_W-1:0]          len;
   logic [lse_pkg::SCALED_W-1:0]       scaled;
   logic [lse_pkg::LEN_W-1:0]          d_x_in;

   lse_pkg::extent_type                d_ext_ff;
   logic [lse_pkg::LEN_W-1:0]          d_x_ff;
   logic [lse_pkg::MPROD_W-1:0]        e_ph_in;
   logic [lse_pkg::MPROD_W-1:0]        e_pl_in;

   lse_pkg::extent_type                e_ext_ff;
   logic [lse_pkg::MPROD_W-1:0]        e_ph_ff;
   logic [lse_pkg::MPROD_W-1:0]        e_pl_ff;
   logic [lse_pkg::QPROD_W-1:0]        qprod;
   logic [lse_pkg::QUOT_W-1:0]         quot;
   logic [lse_pkg::QUOT_W-1:0]         margin;
   logic signed [lse_pkg::T_W-1:0]     margin_t;
   logic signed [lse_pkg::T_W-1:0]     f_t_in [2];
   logic                               f_fb_in;

   logic signed [lse_pkg::T_W-1:0]     f_t_ff [2];
   logic                               f_fb_ff;
   logic signed [lse_pkg::TH_W-1:0]    th [2];
   logic signed [lse_pkg::TL_W:0]      tl [2];
   lse_pkg::coord_type                 lp [lse_pkg::AXES];
   lse_pkg::coord_type                 dir [lse_pkg::AXES];
   logic signed [lse_pkg::EHI_W-1:0]   g_hi_in [2][lse_pkg::AXES];
   logic signed [lse_pkg::ELO_W-1:0]   g_lo_in [2][lse_pkg::AXES];

   logic signed [lse_pkg::EHI_W-1:0]   g_hi_ff [2][lse_pkg::AXES];
   logic signed [lse_pkg::ELO_W-1:0]   g_lo_ff [2][lse_pkg::AXES];
   logic                               g_fb_ff;
   logic signed [lse_pkg::EPROD_W-1:0] eprod [2][lse_pkg::AXES];
   logic signed [lse_pkg::ERND_W-1:0]  ernd [2][lse_pkg::AXES];
   logic signed [lse_pkg::EXT_W-1:0]   ecoord [2][lse_pkg::AXES];
   lse_pkg::coord_type                 coord [2][lse_pkg::AXES];
   lse_pkg::rsp_type                   rsp_in;
   lse_pkg::rsp_type                   rsp_ff;

   // clamp a widened coordinate to the 32-bit field
   function automatic lse_pkg::coord_type sat_coord(
      input logic signed [lse_pkg::EXT_W-1:0] v
   );
      logic [lse_pkg::EXT_W-lse_pkg::COORD_W:0] top;
      lse_pkg::coord_type res;
      top = v[lse_pkg::EXT_W-1:lse_pkg::COORD_W-1];
      if (top == '0 || top == '1) begin
         res = v[lse_pkg::COORD_W-1:0];
      end else if (v[lse_pkg::EXT_W-1]) begin
         res = {1'b1, {(lse_pkg::COORD_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(lse_pkg::COORD_W-1){1'b1}}};
      end
      return res;
   endfunction

   // ready chain, each stage moves when the next one has room
   assign rsp_free   = !rsp_vld_ff || !rsp_stall;
   assign g_rdy      = !g_vld_ff || rsp_free;
   assign f_rdy      = !f_vld_ff || g_rdy;
   assign e_rdy      = !e_vld_ff || f_rdy;
   assign d_rdy      = !d_vld_ff || e_rdy;
   assign c_rdy      = !c_vld_ff || d_rdy;
   assign snap_ready = c_rdy;

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff   <= 1'b0;
         d_vld_ff   <= 1'b0;
         e_vld_ff   <= 1'b0;
         f_vld_ff   <= 1'b0;
         g_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (c_rdy) begin
            c_vld_ff <= snap_valid;
         end
         if (d_rdy) begin
            d_vld_ff <= c_vld_ff;
         end
         if (e_rdy) begin
            e_vld_ff <= d_vld_ff;
         end
         if (f_rdy) begin
            f_vld_ff <= e_vld_ff;
         end
         if (g_rdy) begin
            g_vld_ff <= f_vld_ff;
         end
         if (rsp_free) begin
            rsp_vld_ff <= g_vld_ff;
         end
      end
   end

   // stage c: range length, (3 * len + 10) / 4
   assign span   = (lse_pkg::PROJ_W+1)'(c_ext_ff.max_proj)
                 - (lse_pkg::PROJ_W+1)'(c_ext_ff.min_proj);
   assign len    = span[lse_pkg::LEN_W-1:0];
   assign scaled = {1'b0, len, 1'b0} + {2'b00, len}
                 + lse_pkg::SCALED_W'(lse_pkg::MARGIN_BIAS);
   assign d_x_in = scaled[lse_pkg::SCALED_W-1:2];

   always_ff @(posedge clock) begin
      if (c_rdy && snap_valid) begin
         c_ext_ff <= snap_data;
      end
      if (d_rdy && c_vld_ff) begin
         d_ext_ff <= c_ext_ff;
         d_x_ff   <= d_x_in;
      end
   end

   // stage d: divide by five as two partial products with the reciprocal
   assign e_ph_in = d_x_ff[lse_pkg::LEN_W-1:lse_pkg::XL_W] * lse_pkg::RECIP_FIVE;
   assign e_pl_in = d_x_ff[lse_pkg::XL_W-1:0] * lse_pkg::RECIP_FIVE;

   always_ff @(posedge clock) begin
      if (e_rdy && d_vld_ff) begin
         e_ext_ff <= d_ext_ff;
         e_ph_ff  <= e_ph_in;
         e_pl_ff  <= e_pl_in;
      end
   end

   // stage e: margin and widened range, or the half metre fallback
   assign qprod    = {e_ph_ff, {lse_pkg::XL_W{1'b0}}} + lse_pkg::QPROD_W'(e_pl_ff);
   assign quot     = qprod[lse_pkg::QPROD_W-1:lse_pkg::RECIP_SHIFT];
   assign margin   = (quot < lse_pkg::MARGIN_MIN) ? lse_pkg::MARGIN_MIN : quot;
   assign margin_t = signed'(lse_pkg::T_W'(margin));

   always_comb begin
      if (e_ext_ff.seen) begin
         f_t_in[0] = lse_pkg::T_W'(e_ext_ff.min_proj) - margin_t;
         f_t_in[1] = lse_pkg::T_W'(e_ext_ff.max_proj) + margin_t;
      end else begin
         f_t_in[0] = -lse_pkg::HALF_METRE;
         f_t_in[1] = lse_pkg::HALF_METRE;
      end
   end

   assign f_fb_in = !e_ext_ff.seen;

   always_ff @(posedge clock) begin
      if (f_rdy && e_vld_ff) begin
         f_t_ff[0] <= f_t_in[0];
         f_t_ff[1] <= f_t_in[1];
         f_fb_ff   <= f_fb_in;
      end
   end

   // stage f: t times direction, split at bit 16 of t
   assign lp[0]  = cfg.line_point_x;
   assign lp[1]  = cfg.line_point_y;
   assign lp[2]  = cfg.line_point_z;
   assign dir[0] = cfg.dir_x;
   assign dir[1] = cfg.dir_y;
   assign dir[2] = cfg.dir_z;

   always_comb begin
      for (int e = 0; e < 2; e++) begin
         th[e] = signed'(f_t_ff[e][lse_pkg::T_W-1:lse_pkg::TL_W]);
         tl[e] = signed'({1'b0, f_t_ff[e][lse_pkg::TL_W-1:0]});
         for (int a = 0; a < lse_pkg::AXES; a++) begin
            g_hi_in[e][a] = th[e] * dir[a];
            g_lo_in[e][a] = tl[e] * dir[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (g_rdy && f_vld_ff) begin
         g_fb_ff <= f_fb_ff;
         for (int e = 0; e < 2; e++) begin
            for (int a = 0; a < lse_pkg::AXES; a++) begin
               g_hi_ff[e][a] <= g_hi_in[e][a];
               g_lo_ff[e][a] <= g_lo_in[e][a];
            end
         end
      end
   end

   // stage g: join partials, round half up, add line point, saturate
   always_comb begin
      for (int e = 0; e < 2; e++) begin
         for (int a = 0; a < lse_pkg::AXES; a++) begin
            eprod[e][a] = (lse_pkg::EPROD_W'(g_hi_ff[e][a]) <<< lse_pkg::TL_W)
                        + lse_pkg::EPROD_W'(g_lo_ff[e][a])
                        + lse_pkg::EPROD_W'(lse_pkg::Q30_HALF);
            ernd[e][a]   = eprod[e][a][lse_pkg::EPROD_W-1:lse_pkg::Q30_SHIFT];
            ecoord[e][a] = lse_pkg::EXT_W'(ernd[e][a]) + lse_pkg::EXT_W'(lp[a]);
            coord[e][a]  = sat_coord(ecoord[e][a]);
         end
      end
   end

   always_comb begin
      rsp_in.start_x       = coord[0][0];
      rsp_in.start_y       = coord[0][1];
      rsp_in.start_z       = coord[0][2];
      rsp_in.finish_x      = coord[1][0];
      rsp_in.finish_y      = coord[1][1];
      rsp_in.finish_z      = coord[1][2];
      rsp_in.used_fallback = g_fb_ff;
   end

   // result register, holds while stalled
   always_ff @(posedge clock) begin
      if (rsp_free && g_vld_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule
